// ===== rtl/core/tick_driven_timestamp_clock_defines.svh =====
// ----------------------------------------------------------------------------
// tick driven timestamp clock - assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef TICK_DRIVEN_TIMESTAMP_CLOCK_DEFINES_SVH
`define TICK_DRIVEN_TIMESTAMP_CLOCK_DEFINES_SVH

// same-cycle implication, masked during reset
`define TDTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define TDTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked across reset
`define TDTC_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tdtc_pkg.sv =====
// ----------------------------------------------------------------------------
// tdtc_pkg
// widths, constants and stage types of the tick driven timestamp clock
// ----------------------------------------------------------------------------
package tdtc_pkg;

   localparam int unsigned TICKS_PER_SECOND = 1000;

   localparam int unsigned TIME_W  = 64;
   localparam int unsigned TICK_W  = 32;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned GAP_W   = 16;

   localparam logic [GAP_W-1:0]  MIN_GAP_RESET = GAP_W'(10);
   localparam logic [TICK_W-1:0] FRAC_FULL     = 32'hFFFF_FFFF;
   localparam logic [TICK_W-1:0] FRAC_STEP     = FRAC_FULL / TICKS_PER_SECOND;

   // floor reciprocal, quotient is exact or one low
   localparam int unsigned       RECIP_SHIFT = 38;
   localparam longint unsigned   RECIP =
      (64'd1 << RECIP_SHIFT) / 64'(TICKS_PER_SECOND);
   localparam int unsigned       RECIP_W = $clog2(RECIP + 1);
   localparam int unsigned       QPROD_W = TICK_W + RECIP_W;
   localparam int unsigned       REST_W  = $clog2(TICKS_PER_SECOND + 1);

   localparam logic KIND_SET     = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [TIME_W-1:0] new_time;
      logic [TICK_W-1:0] current_tick;
      logic              force_update;
   } req_item_type;

   typedef struct packed {
      logic               is_set;
      logic               advance;
      logic [TIME_W-1:0]  new_time;
      logic [COUNT_W-1:0] set_count;
   } item_type;

   typedef struct packed {
      item_type          item;
      logic [TICK_W-1:0] gap;
   } gap_item_type;

   typedef struct packed {
      item_type          item;
      logic [TICK_W-1:0] gap;
      logic [TICK_W-1:0] quot;
   } quot_item_type;

   typedef struct packed {
      item_type          item;
      logic [TICK_W-1:0] secs;
      logic [REST_W-1:0] rest;
   } rest_item_type;

   typedef struct packed {
      item_type          item;
      logic [TICK_W-1:0] secs;
      logic [TICK_W-1:0] add_frac;
   } step_item_type;

endpackage

// ===== rtl/core/tick_driven_timestamp_clock.sv =====
// ----------------------------------------------------------------------------
// tick_driven_timestamp_clock
// seconds.fraction timestamp advanced from a millisecond tick counter
// ----------------------------------------------------------------------------
// channel   direction   handshake              payload
// req       in          req_valid / req_stall  kind, new_time, current_tick, force_update
// rsp       out         rsp_valid / rsp_stall  local_time, time_changed, set_count
// csr       in          csr_valid / csr_ready  min_update_gap
//
// one transaction per cycle sustained while rsp_stall is low
// each result passes through the input register, gap stage, three divide/scale
// stages and the timestamp register
// synchronous reset, no clearing pass; csr_ready is always high
// rsp_stall backs up one stage at a time, req_stall rises once all are full
// ----------------------------------------------------------------------------
module tick_driven_timestamp_clock (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [tdtc_pkg::TIME_W-1:0]   req_new_time,
   input  logic [tdtc_pkg::TICK_W-1:0]   req_current_tick,
   input  logic                          req_force_update,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tdtc_pkg::TIME_W-1:0]   rsp_local_time,
   output logic                          rsp_time_changed,
   output logic [tdtc_pkg::COUNT_W-1:0]  rsp_set_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tdtc_pkg::GAP_W-1:0]    csr_min_update_gap
);
   import tdtc_pkg::*;

   logic           gap_valid;
   logic           gap_ready;
   gap_item_type   gap_item;
   logic           step_valid;
   logic           step_ready;
   step_item_type  step_item;

   tdtc_gate u_gate (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_new_time       (req_new_time),
      .req_current_tick   (req_current_tick),
      .req_force_update   (req_force_update),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_min_update_gap (csr_min_update_gap),
      .out_valid          (gap_valid),
      .out_ready          (gap_ready),
      .out_item           (gap_item)
   );

   tdtc_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (gap_valid),
      .in_ready  (gap_ready),
      .in_item   (gap_item),
      .out_valid (step_valid),
      .out_ready (step_ready),
      .out_item  (step_item)
   );

   tdtc_accum u_accum (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (step_valid),
      .in_ready         (step_ready),
      .in_item          (step_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_local_time   (rsp_local_time),
      .rsp_time_changed (rsp_time_changed),
      .rsp_set_count    (rsp_set_count)
   );

endmodule

// ===== rtl/core/tdtc_gate.sv =====
// ----------------------------------------------------------------------------
// tdtc_gate
// input register, tick gap, update decision, reference tick and set count
// ----------------------------------------------------------------------------
module tdtc_gate (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [tdtc_pkg::TIME_W-1:0]   req_new_time,
   input  logic [tdtc_pkg::TICK_W-1:0]   req_current_tick,
   input  logic                          req_force_update,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tdtc_pkg::GAP_W-1:0]    csr_min_update_gap,
   output logic                          out_valid,
   input  logic                          out_ready,
   output tdtc_pkg::gap_item_type        out_item
);
   import tdtc_pkg::*;

   logic                in_valid_ff, in_valid_in;
   req_item_type        in_item_ff;
   logic                gate_valid_ff, gate_valid_in;
   gap_item_type        gate_item_ff, gate_item_in;
   logic [TICK_W-1:0]   last_tick_ff, last_tick_in;
   logic [COUNT_W-1:0]  sets_done_ff, sets_done_in;
   logic [GAP_W-1:0]    min_gap_ff, min_gap_in;
   logic                in_en;
   logic                gate_en;
   logic                move;
   logic [TICK_W-1:0]   gap;
   logic                is_set;
   logic                advance;

   assign gate_en   = !gate_valid_ff || out_ready;
   assign in_en     = !in_valid_ff || gate_en;
   assign req_stall = !in_en;
   assign csr_ready = 1'b1;
   assign move      = in_valid_ff && gate_en;

   assign gap     = in_item_ff.current_tick - last_tick_ff;
   assign is_set  = (in_item_ff.kind == KIND_SET);
   assign advance = !is_set &&
                    (in_item_ff.force_update || (gap >= TICK_W'(min_gap_ff)));

   always_comb begin
      in_valid_in   = in_en ? req_valid : in_valid_ff;
      gate_valid_in = gate_en ? in_valid_ff : gate_valid_ff;
      last_tick_in  = last_tick_ff;
      sets_done_in  = sets_done_ff;
      min_gap_in    = (csr_valid && csr_ready) ? csr_min_update_gap : min_gap_ff;
      if (move && (is_set || advance)) begin
         last_tick_in = in_item_ff.current_tick;
      end
      if (move && is_set) begin
         sets_done_in = sets_done_ff + COUNT_W'(1);
      end
      gate_item_in.item.is_set    = is_set;
      gate_item_in.item.advance   = advance;
      gate_item_in.item.new_time  = in_item_ff.new_time;
      gate_item_in.item.set_count = is_set ? sets_done_ff + COUNT_W'(1) : sets_done_ff;
      gate_item_in.gap            = gap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         gate_valid_ff <= 1'b0;
         last_tick_ff  <= '0;
         sets_done_ff  <= '0;
         min_gap_ff    <= MIN_GAP_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         gate_valid_ff <= gate_valid_in;
         last_tick_ff  <= last_tick_in;
         sets_done_ff  <= sets_done_in;
         min_gap_ff    <= min_gap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_en) begin
         in_item_ff.kind         <= req_kind;
         in_item_ff.new_time     <= req_new_time;
         in_item_ff.current_tick <= req_current_tick;
         in_item_ff.force_update <= req_force_update;
      end
      if (gate_en) begin
         gate_item_ff <= gate_item_in;
      end
   end

   assign out_valid = gate_valid_ff;
   assign out_item  = gate_item_ff;

endmodule

// ===== rtl/core/tdtc_split.sv =====
// ----------------------------------------------------------------------------
// tdtc_split
// splits the tick gap into seconds and fraction units over three stages
// ----------------------------------------------------------------------------
module tdtc_split (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  tdtc_pkg::gap_item_type   in_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output tdtc_pkg::step_item_type  out_item
);
   import tdtc_pkg::*;

   logic               quot_valid_ff, quot_valid_in;
   quot_item_type      quot_item_ff, quot_item_in;
   logic               rest_valid_ff, rest_valid_in;
   rest_item_type      rest_item_ff, rest_item_in;
   logic               step_valid_ff, step_valid_in;
   step_item_type      step_item_ff, step_item_in;
   logic               quot_en, rest_en, step_en;
   logic [QPROD_W-1:0] quot_prod;
   logic [TICK_W-1:0]  rem_raw;
   logic               rem_fix;

   assign step_en  = !step_valid_ff || out_ready;
   assign rest_en  = !rest_valid_ff || step_en;
   assign quot_en  = !quot_valid_ff || rest_en;
   assign in_ready = quot_en;

   // quotient estimate by reciprocal
   assign quot_prod = QPROD_W'(in_item.gap) * QPROD_W'(RECIP);

   // remainder with one correction step
   assign rem_raw = quot_item_ff.gap -
                    TICK_W'(quot_item_ff.quot * TICK_W'(TICKS_PER_SECOND));
   assign rem_fix = (rem_raw >= TICK_W'(TICKS_PER_SECOND));

   always_comb begin
      quot_valid_in = quot_en ? in_valid : quot_valid_ff;
      rest_valid_in = rest_en ? quot_valid_ff : rest_valid_ff;
      step_valid_in = step_en ? rest_valid_ff : step_valid_ff;

      quot_item_in.item = in_item.item;
      quot_item_in.gap  = in_item.gap;
      quot_item_in.quot = TICK_W'(quot_prod >> RECIP_SHIFT);

      rest_item_in.item = quot_item_ff.item;
      rest_item_in.secs = quot_item_ff.quot + TICK_W'(rem_fix);
      rest_item_in.rest = rem_fix ? REST_W'(rem_raw - TICK_W'(TICKS_PER_SECOND))
                                  : REST_W'(rem_raw);

      step_item_in.item     = rest_item_ff.item;
      step_item_in.secs     = rest_item_ff.secs;
      step_item_in.add_frac = TICK_W'(TICK_W'(rest_item_ff.rest) * FRAC_STEP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_valid_ff <= 1'b0;
         rest_valid_ff <= 1'b0;
         step_valid_ff <= 1'b0;
      end else begin
         quot_valid_ff <= quot_valid_in;
         rest_valid_ff <= rest_valid_in;
         step_valid_ff <= step_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (quot_en) begin
         quot_item_ff <= quot_item_in;
      end
      if (rest_en) begin
         rest_item_ff <= rest_item_in;
      end
      if (step_en) begin
         step_item_ff <= step_item_in;
      end
   end

   assign out_valid = step_valid_ff;
   assign out_item  = step_item_ff;

endmodule

// ===== rtl/core/tdtc_accum.sv =====
// ----------------------------------------------------------------------------
// tdtc_accum
// timestamp register and result register
// ----------------------------------------------------------------------------
module tdtc_accum (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  tdtc_pkg::step_item_type        in_item,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tdtc_pkg::TIME_W-1:0]    rsp_local_time,
   output logic                           rsp_time_changed,
   output logic [tdtc_pkg::COUNT_W-1:0]   rsp_set_count
);
   import tdtc_pkg::*;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic                changed_ff, changed_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                out_en;
   logic                move;
   logic [TICK_W:0]     frac_sum;
   logic [TICK_W-1:0]   secs_sum;

   assign out_en   = !rsp_valid_ff || !rsp_stall;
   assign in_ready = out_en;
   assign move     = in_valid && out_en;

   assign frac_sum = (TICK_W+1)'(time_ff[TICK_W-1:0]) + (TICK_W+1)'(in_item.add_frac);
   assign secs_sum = time_ff[TIME_W-1:TICK_W] + in_item.secs + TICK_W'(frac_sum[TICK_W]);

   always_comb begin
      rsp_valid_in = out_en ? in_valid : rsp_valid_ff;
      time_in      = time_ff;
      changed_in   = changed_ff;
      count_in     = count_ff;
      if (move) begin
         priority if (in_item.item.is_set) begin
            time_in = in_item.item.new_time;
         end else if (in_item.item.advance) begin
            time_in = {secs_sum, frac_sum[TICK_W-1:0]};
         end else begin
            time_in = time_ff;
         end
         changed_in = in_item.item.is_set || in_item.item.advance;
         count_in   = in_item.item.set_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         time_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         time_ff      <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      changed_ff <= changed_in;
      count_ff   <= count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_local_time   = time_ff;
   assign rsp_time_changed = changed_ff;
   assign rsp_set_count    = count_ff;

endmodule

// ===== rtl/core/tdtc_checker.sv =====
// ----------------------------------------------------------------------------
// tdtc_checker
// port level checks of the tick driven timestamp clock
// ----------------------------------------------------------------------------
`include "tick_driven_timestamp_clock_defines.svh"

module tdtc_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_kind,
   input  logic [tdtc_pkg::TIME_W-1:0]   req_new_time,
   input  logic [tdtc_pkg::TICK_W-1:0]   req_current_tick,
   input  logic                          req_force_update,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [tdtc_pkg::TIME_W-1:0]   rsp_local_time,
   input  logic                          rsp_time_changed,
   input  logic [tdtc_pkg::COUNT_W-1:0]  rsp_set_count,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [tdtc_pkg::GAP_W-1:0]    csr_min_update_gap
);

   // a held result keeps its payload
   `TDTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_local_time) && $stable(rsp_time_changed) && $stable(rsp_set_count), "rsp payload changed while stalled")

   // input back-pressure only comes from a blocked result
   `TDTC_ASSERT_NOW(a_req_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "req stalled without rsp stall")

   // pipeline empties on reset
   `TDTC_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall, "pipeline not empty after reset")

   // csr writes are never refused
   `TDTC_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready, "csr write refused")

endmodule

bind tick_driven_timestamp_clock tdtc_checker u_checker (.*);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb - tick driven timestamp clock testbench
// a stimulus table of set and advance transactions, then random traffic over
// several minimum-gap settings and idle mixes; every response is compared field
// by field with the row's typed result or a timestamp predictor kept in step with the stimulus
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tdtc_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned ITEMS_PER_PHASE = 125;
   localparam int unsigned ROW_COUNT = 20;
   localparam logic [TICK_W-1:0] FRAC_PER_TICK = 32'hFFFF_FFFF / TICKS_PER_SECOND;

   typedef struct packed {
      logic [TIME_W-1:0]  local_time;
      logic               time_changed;
      logic [COUNT_W-1:0] set_count;
   } stamp_result_type;

   typedef struct packed {
      logic              kind;
      logic [TIME_W-1:0] new_time;
      logic [TICK_W-1:0] tick;
      logic              forced;
      logic              typed;
      stamp_result_type  result;
   } stamp_row_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_kind = KIND_SET;
   logic [TIME_W-1:0]   req_new_time = '0;
   logic [TICK_W-1:0]   req_current_tick = '0;
   logic                req_force_update = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [TIME_W-1:0]   rsp_local_time;
   logic                rsp_time_changed;
   logic [COUNT_W-1:0]  rsp_set_count;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [GAP_W-1:0]    csr_min_update_gap = '0;

   // predictor state
   logic [TIME_W-1:0]   stamp_model;
   logic [TICK_W-1:0]   last_tick_model;
   logic [COUNT_W-1:0]  sets_model;
   logic [GAP_W-1:0]    min_gap_model;

   stamp_result_type    expected_stamps [$];
   int unsigned         fail_count = 0;
   int unsigned         send_idle_pct = 0;
   int unsigned         recv_idle_pct = 0;
   int unsigned         quiet_cycles = 0;

   stamp_row_type directed_rows [ROW_COUNT] = '{
      '{KIND_ADVANCE, 64'h0, 32'h0, 1'b0, 1'b1, '{64'h0, 1'b0, 32'd0}},
      '{KIND_ADVANCE, 64'h0, 32'h0, 1'b1, 1'b1, '{64'h0, 1'b1, 32'd0}},
      '{KIND_ADVANCE, 64'h0, 32'd9, 1'b0, 1'b1, '{64'h0, 1'b0, 32'd0}},
      '{KIND_ADVANCE, 64'h0, 32'd10, 1'b0, 1'b1, '{64'd42949670, 1'b1, 32'd0}},
      '{KIND_ADVANCE, 64'h0, 32'd1010, 1'b0, 1'b0, '0},
      '{KIND_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'd1}},
      '{KIND_ADVANCE, 64'h0, 32'hFFFF_FFFF, 1'b1, 1'b1,
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'd1}},
      '{KIND_ADVANCE, 64'h0, 32'd9, 1'b0, 1'b0, '0},
      '{KIND_SET, 64'h0, 32'h0, 1'b0, 1'b1, '{64'h0, 1'b1, 32'd2}},
      '{KIND_ADVANCE, 64'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
      '{KIND_SET, 64'hFFFF_FFFF_0000_0000, 32'd100, 1'b0, 1'b1,
        '{64'hFFFF_FFFF_0000_0000, 1'b1, 32'd3}},
      '{KIND_ADVANCE, 64'h0, 32'd99, 1'b0, 1'b0, '0},
      '{KIND_ADVANCE, 64'h0, 32'd1098, 1'b0, 1'b0, '0},
      '{KIND_SET, 64'h0000_0000_FFFF_FFFF, 32'h8000_0000, 1'b0, 1'b1,
        '{64'h0000_0000_FFFF_FFFF, 1'b1, 32'd4}},
      '{KIND_ADVANCE, 64'h0, 32'h8000_0001, 1'b1, 1'b0, '0},
      '{KIND_SET, 64'hAAAA_AAAA_5555_5555, 32'h5555_5555, 1'b0, 1'b1,
        '{64'hAAAA_AAAA_5555_5555, 1'b1, 32'd5}},
      '{KIND_ADVANCE, 64'h0, 32'hAAAA_AAAA, 1'b0, 1'b0, '0},
      '{KIND_ADVANCE, 64'h0, 32'hAAAA_AAAF, 1'b0, 1'b0, '0},
      '{KIND_SET, 64'h5555_5555_AAAA_AAAA, 32'hAAAA_AAAA, 1'b1, 1'b1,
        '{64'h5555_5555_AAAA_AAAA, 1'b1, 32'd6}},
      '{KIND_ADVANCE, 64'h0, 32'hAAAA_B27A, 1'b0, 1'b0, '0}
   };

   tick_driven_timestamp_clock uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_new_time       (req_new_time),
      .req_current_tick   (req_current_tick),
      .req_force_update   (req_force_update),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_local_time     (rsp_local_time),
      .rsp_time_changed   (rsp_time_changed),
      .rsp_set_count      (rsp_set_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_min_update_gap (csr_min_update_gap)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [TIME_W-1:0] advance_stamp(logic [TIME_W-1:0] stamp,
                                                       logic [TICK_W-1:0] gap);
      logic [TICK_W-1:0] secs;
      logic [TICK_W-1:0] rest;
      logic [TICK_W-1:0] add_frac;
      logic [TICK_W-1:0] frac_sum;
      logic              carry;
      secs = gap / TICKS_PER_SECOND;
      rest = gap % TICKS_PER_SECOND;
      add_frac = rest * FRAC_PER_TICK;
      {carry, frac_sum} = {1'b0, stamp[31:0]} + {1'b0, add_frac};
      return {stamp[63:32] + secs + 32'(carry), frac_sum};
   endfunction

   function automatic stamp_result_type predict_stamp(logic kind,
                                                      logic [TIME_W-1:0] new_time,
                                                      logic [TICK_W-1:0] tick,
                                                      logic forced);
      stamp_result_type  res;
      logic [TICK_W-1:0] gap;
      res.time_changed = 1'b0;
      if (kind == KIND_SET) begin
         sets_model = sets_model + 32'd1;
         stamp_model = new_time;
         last_tick_model = tick;
         res.time_changed = 1'b1;
      end else begin
         gap = tick - last_tick_model;
         if (gap >= 32'(min_gap_model) || forced) begin
            stamp_model = advance_stamp(stamp_model, gap);
            last_tick_model = tick;
            res.time_changed = 1'b1;
         end
      end
      res.local_time = stamp_model;
      res.set_count = sets_model;
      return res;
   endfunction

   task automatic drive_stamp_req(input logic kind, input logic [TIME_W-1:0] new_time,
                                  input logic [TICK_W-1:0] tick, input logic forced,
                                  input logic typed, input stamp_result_type typed_result);
      stamp_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_new_time <= new_time;
      req_current_tick <= tick;
      req_force_update <= forced;
      do @(posedge clock); while (req_stall);
      predicted = predict_stamp(kind, new_time, tick, forced);
      expected_stamps.push_back(typed ? typed_result : predicted);
   endtask

   task automatic send_random_stamp();
      logic              kind;
      logic              forced;
      logic [TIME_W-1:0] new_time;
      logic [TICK_W-1:0] gap;
      int unsigned       pick;
      kind = ($urandom_range(99) < 15) ? KIND_SET : KIND_ADVANCE;
      forced = ($urandom_range(99) < 25);
      if ($urandom_range(99) < 70) begin
         new_time = {$urandom, $urandom};
      end else begin
         new_time = {32'hFFFF_FFFF - 32'($urandom_range(3)),
                     32'hFFFF_FFFF - 32'($urandom_range(5000000))};
      end
      pick = $urandom_range(99);
      if (pick < 40) begin
         gap = 32'(min_gap_model) + 32'($urandom_range(2000));
      end else if (pick < 55) begin
         gap = 32'($urandom_range(32'(min_gap_model)));
      end else if (pick < 65) begin
         gap = 32'(min_gap_model) - 32'($urandom_range(1));
      end else if (pick < 85) begin
         gap = 32'($urandom_range(5000000));
      end else begin
         gap = $urandom - last_tick_model;
      end
      drive_stamp_req(kind, new_time, last_tick_model + gap, forced, 1'b0, '0);
   endtask

   task automatic wait_drained();
      while (expected_stamps.size() != 0) @(posedge clock);
   endtask

   task automatic write_min_gap(input logic [GAP_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_min_update_gap <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      min_gap_model = value;
   endtask

   // response check and receiver stall
   always @(posedge clock) begin
      stamp_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_stamps.size() == 0) begin
            $display("%0t: response with nothing pending, local_time %h", $time,
                     rsp_local_time);
            fail_count++;
         end else begin
            want = expected_stamps.pop_front();
            if (rsp_local_time !== want.local_time) begin
               $display("%0t: local_time expected %h actual %h", $time,
                        want.local_time, rsp_local_time);
               fail_count++;
            end
            if (rsp_time_changed !== want.time_changed) begin
               $display("%0t: time_changed expected %b actual %b", $time,
                        want.time_changed, rsp_time_changed);
               fail_count++;
            end
            if (rsp_set_count !== want.set_count) begin
               $display("%0t: set_count expected %h actual %h", $time,
                        want.set_count, rsp_set_count);
               fail_count++;
            end
         end
      end
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[tick_driven_timestamp_clock] ERROR");
         $finish;
      end
   end

   initial begin
      logic [GAP_W-1:0] phase_gap;
      stamp_model = '0;
      last_tick_model = '0;
      sets_model = '0;
      min_gap_model = MIN_GAP_RESET;
      send_idle_pct = 32;
      recv_idle_pct = 49;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         drive_stamp_req(directed_rows[i].kind, directed_rows[i].new_time,
                         directed_rows[i].tick, directed_rows[i].forced,
                         directed_rows[i].typed, directed_rows[i].result);
      end
      req_valid <= 1'b0;

      for (int p = 0; p < 6; p++) begin
         case (p / 2)
            0: begin
               send_idle_pct = 32;
               recv_idle_pct = 49;
            end
            1: begin
               send_idle_pct = 49;
               recv_idle_pct = 32;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (p)
            0: phase_gap = 16'd0;
            1: phase_gap = 16'hFFFF;
            2: phase_gap = 16'd1;
            3: phase_gap = 16'd1000;
            4: phase_gap = 16'($urandom);
            default: phase_gap = MIN_GAP_RESET;
         endcase
         write_min_gap(phase_gap);
         repeat (ITEMS_PER_PHASE) send_random_stamp();
         req_valid <= 1'b0;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_stamps.size() == 0) begin
         $display("[tick_driven_timestamp_clock] OK");
      end else begin
         $display("[tick_driven_timestamp_clock] ERROR");
      end
      $finish;
   end

endmodule
